@@ design/kschash_pkg.sv @@
// shared types, constants and the id shuffle for the keyed string code hash
// no dependencies; imported by the controller, the datapath and the top level

package kschash_pkg;

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CODE_W = 32;
    localparam int unsigned S_DATA_W = 40;  // key_id and text_byte, already whole bytes

    localparam logic [31:0] MASK_B0 = 32'h0000_00FF;
    localparam logic [31:0] MASK_B1 = 32'h0000_FF00;
    localparam logic [31:0] MASK_B2 = 32'h00FF_0000;
    localparam logic [31:0] MASK_B3 = 32'hFF00_0000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic step;   // take one input word
        logic empty;  // the word carries no byte
        logic fin1;   // first multiply of the final mix, clear the string state
        logic fin2;   // second multiply, load the result register
    } t_cmd;

    // byte-shuffled form of the id
    function automatic logic [31:0] shuffle_key(input logic [31:0] id);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] hi;
        logic [7:0] lo;
        b0 = 8'(id & MASK_B0);
        b1 = 8'((id & MASK_B1) >> 8);
        b2 = 8'((id & MASK_B2) >> 16);
        b3 = 8'((id & MASK_B3) >> 24);
        hi = (b2 == 8'd0) ? ~b1 : b2;
        lo = (b3 == 8'd0) ? ~b0 : b3;
        return {b0, hi, b1, lo};
    endfunction

endpackage

@@ design/kschash_ctrl.sv @@
// controller for the keyed string code hash: handshakes and final mix sequencing
// depends on kschash_pkg (t_cmd)

module kschash_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_final,
    input  logic                i_in_empty,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kschash_pkg::t_cmd   o_cmd
);
    import kschash_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    // the result register may take a new code once the old one is gone
    assign w_load      = (r_state == S_MUL2) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.step  = w_accept;
    assign o_cmd.empty = i_in_empty;
    assign o_cmd.fin1  = (r_state == S_MUL1);
    assign o_cmd.fin2  = w_load;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_in_final) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                if (w_load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_final_starts_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_final) |=> (r_state == S_MUL1))
        else $error("final word did not start the mix");

    a_mul1_to_mul2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |=> (r_state == S_MUL2))
        else $error("first multiply not followed by second");

    a_result_from_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_MUL2))
        else $error("result raised outside the final multiply");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> !$past(w_load))
        else $error("pending result overwritten");

endmodule

@@ design/kschash_dp.sv @@
// datapath for the keyed string code hash: accumulators, held id and final mix
// depends on kschash_pkg (t_cmd, shuffle_key, widths)

module kschash_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kschash_pkg::t_cmd               i_cmd,
    input  logic [kschash_pkg::KEY_W-1:0]   i_key_id,
    input  logic [kschash_pkg::BYTE_W-1:0]  i_text_byte,
    output logic [kschash_pkg::CODE_W-1:0]  o_code
);
    import kschash_pkg::*;

    logic [31:0] r_fwd;
    logic [31:0] r_rev;
    logic [31:0] r_weight;
    logic        r_odd;
    logic        r_mid;
    logic [31:0] r_key;
    logic [31:0] r_prod1;
    logic [31:0] r_rx;
    logic [31:0] r_code;

    logic [31:0] w_c;
    logic [31:0] w_fwd_next;
    logic [31:0] w_wgt_next;
    logic signed [40:0] w_cw;
    logic [31:0] w_key;
    logic [31:0] w_shuf;
    logic [31:0] w_sum;
    logic [63:0] w_p1;
    logic [63:0] w_p2;

    assign w_c = {{24{i_text_byte[7]}}, i_text_byte};
    assign w_fwd_next = r_odd ? (w_c + r_fwd + (r_fwd << 4)) : (w_c + r_fwd + (r_fwd << 3));
    assign w_wgt_next = r_odd ? (r_weight + (r_weight << 5)) : (r_weight + (r_weight << 4));
    // signed byte times weight, low 32 bits match the wrapped product
    assign w_cw = $signed(i_text_byte) * $signed({1'b0, r_weight});

    // first word of a string latches the id; it is not stored until the clock edge
    assign w_key  = r_key;
    assign w_shuf = shuffle_key(w_key);
    assign w_sum  = (r_rev ^ w_shuf) + (r_fwd | w_key);
    assign w_p1   = w_sum * (r_fwd | w_shuf);
    assign w_p2   = r_prod1 * r_rx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd    <= '0;
            r_rev    <= '0;
            r_weight <= 32'd1;
            r_odd    <= 1'b0;
            r_mid    <= 1'b0;
            r_key    <= '0;
        end else if (i_cmd.fin1) begin
            r_fwd    <= '0;
            r_rev    <= '0;
            r_weight <= 32'd1;
            r_odd    <= 1'b0;
            r_mid    <= 1'b0;
        end else if (i_cmd.step) begin
            if (!r_mid) begin
                r_key <= i_key_id;
                r_mid <= 1'b1;
            end
            if (!i_cmd.empty) begin
                r_fwd    <= w_fwd_next;
                r_rev    <= r_rev + w_cw[31:0];
                r_weight <= w_wgt_next;
                r_odd    <= ~r_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin1) begin
            r_prod1 <= w_p1[31:0];
            r_rx    <= r_rev ^ w_key;
        end
        if (i_cmd.fin2) begin
            r_code <= w_p2[31:0];
        end
    end

    assign o_code = r_code;

endmodule

@@ design/keyed_string_code_hash.sv @@
// top level of the keyed string code hash: stream ports, controller and datapath
// depends on kschash_pkg, kschash_ctrl, kschash_dp
//
//  channel  | dir | tdata (low bit up)             | tlast     | tuser
//  s_axis   | in  | key_id[31:0], text_byte[39:32] | last_byte | empty_text
//  m_axis   | out | code[31:0]                     | -         | -
//
// a byte that does not end its string leaves the input ready for the next word
// a final word (tlast or tuser set) runs the byte update (skipped for empty_text), then two
//   registered 32x32 multiplies of the final mix
// the result register lets the next string start while a code waits; a second
//   code stalls in the last multiply until m_axis_tready frees the register
// synchronous active-low reset clears the accumulators, the held id and the output valid

module keyed_string_code_hash (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [kschash_pkg::S_DATA_W-1:0]    s_axis_tdata,  // key_id, text_byte
    input  logic                                s_axis_tlast,  // last_byte
    input  logic                                s_axis_tuser,  // empty_text
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [kschash_pkg::CODE_W-1:0]      m_axis_tdata   // code
);
    import kschash_pkg::*;

    t_cmd w_cmd;

    kschash_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_final  (s_axis_tlast | s_axis_tuser),
        .i_in_empty  (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    kschash_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_key_id    (s_axis_tdata[KEY_W-1:0]),
        .i_text_byte (s_axis_tdata[KEY_W+BYTE_W-1:KEY_W]),
        .o_code      (m_axis_tdata)
    );

endmodule
